// File: hw/rtl/dclf_pkg.sv
`timescale 1ns / 1ps

package dclf_pkg;

    // Hold buffer and queue sizing
    localparam int HOLD_DEPTH  = 8;
    localparam int HOLD_IDX_W  = 3;
    localparam int CNT_W       = 4;
    localparam int NUM_KEYS    = 4;
    localparam int KEY_SLOTS   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Line modes
    localparam logic [1:0] MODE_MATCH = 2'd0;
    localparam logic [1:0] MODE_PASS  = 2'd1;
    localparam logic [1:0] MODE_DROP  = 2'd2;

    // Characters
    localparam logic [7:0] PCT     = 8'h25;
    localparam logic [7:0] NEWLINE = 8'h0a;

    // Commands from front to back
    localparam logic [1:0] CMD_HOLD    = 2'd0;
    localparam logic [1:0] CMD_DISCARD = 2'd1;
    localparam logic [1:0] CMD_EMIT    = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } cmd_t;

    // Keywords after the two percent signs: EOF, BEGIN, END, TRAILER
    localparam logic [7:0] KEY_TEXT [NUM_KEYS][KEY_SLOTS] = '{
        '{8'h45, 8'h4f, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h45, 8'h47, 8'h49, 8'h4e, 8'h00, 8'h00, 8'h00},
        '{8'h45, 8'h4e, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h54, 8'h52, 8'h41, 8'h49, 8'h4c, 8'h45, 8'h52, 8'h00}
    };
    localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{3'd3, 3'd5, 3'd3, 3'd7};

    // Fold a-z to upper case, leave every other byte alone
    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7a)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/dclf_if.sv
`timescale 1ns / 1ps

interface dclf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface dclf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: hw/rtl/dclf_front.sv
`timescale 1ns / 1ps

module dclf_front
    import dclf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    dclf_in_if.sink      in_ch,
    input  logic         q_full,
    output logic         push,
    output cmd_t         push_cmd
);

    logic [1:0]          mode_reg, mode_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NUM_KEYS-1:0] alive_reg, alive_next;
    logic                accept;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;

    // Classify the word and pick the command for the back end
    always_comb
    begin
        logic [7:0]          b;
        logic [7:0]          u;
        logic [CNT_W-1:0]    k_w;
        logic [2:0]          k;
        logic [NUM_KEYS-1:0] alive_n;
        logic                full;
        b          = in_ch.data_byte;
        u          = fold_upper(b);
        k_w        = cnt_reg - CNT_W'(2);
        k          = k_w[2:0];
        alive_n    = alive_reg;
        full       = 1'b0;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        alive_next = alive_reg;
        push       = 1'b0;
        push_cmd   = '{kind: CMD_EMIT, data: b};

        case (mode_reg)
            MODE_PASS:
            begin
                push = 1'b1;
                if (b == NEWLINE)
                begin
                    mode_next = MODE_MATCH;
                end
            end
            MODE_DROP:
            begin
                if (b == NEWLINE)
                begin
                    mode_next = MODE_MATCH;
                end
            end
            default:
            begin
                // Match the prefix against all keywords at once
                if (cnt_reg < CNT_W'(2))
                begin
                    if (b != PCT)
                    begin
                        alive_n = '0;
                    end
                end
                else
                begin
                    for (int i = 0; i < NUM_KEYS; i++)
                    begin
                        if (alive_reg[i])
                        begin
                            if (k < KEY_LEN[i] && u == KEY_TEXT[i][k])
                            begin
                                if (({1'b0, k} + 4'd1) == {1'b0, KEY_LEN[i]})
                                begin
                                    full = 1'b1;
                                end
                            end
                            else
                            begin
                                alive_n[i] = 1'b0;
                            end
                        end
                    end
                end

                push = 1'b1;
                if (full)
                begin
                    push_cmd.kind = CMD_DISCARD;
                    cnt_next      = '0;
                    alive_next    = '1;
                    mode_next     = MODE_DROP;
                end
                else if (alive_n == '0 || cnt_reg >= CNT_W'(HOLD_DEPTH))
                begin
                    push_cmd.kind = CMD_EMIT;
                    cnt_next      = '0;
                    alive_next    = '1;
                    mode_next     = (b == NEWLINE) ? MODE_MATCH : MODE_PASS;
                end
                else
                begin
                    // At end of data a held word is released at once
                    push_cmd.kind = in_ch.end_of_data ? CMD_EMIT : CMD_HOLD;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    alive_next    = alive_n;
                    mode_next     = MODE_MATCH;
                end
            end
        endcase

        // End of data returns to line start
        if (in_ch.end_of_data)
        begin
            mode_next  = MODE_MATCH;
            cnt_next   = '0;
            alive_next = '1;
        end

        if (!accept)
        begin
            push = 1'b0;
        end
    end

    // Advance line state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_MATCH;
            cnt_reg   <= '0;
            alive_reg <= '1;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            alive_reg <= alive_next;
        end
    end

endmodule

// File: hw/rtl/dclf_queue.sv
`timescale 1ns / 1ps

module dclf_queue
    import dclf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Store commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/dclf_back.sv
`timescale 1ns / 1ps

module dclf_back
    import dclf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         head_valid,
    input  cmd_t         head,
    output logic         pop,
    dclf_out_if.source   out_ch
);

    logic [7:0]       held_reg [HOLD_DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             load_ok;
    logic             hold_wr;

    assign load_ok            = !out_valid_reg || out_ch.ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.last_of_run = out_last_reg;

    // Execute the head command
    always_comb
    begin
        pop            = 1'b0;
        hold_wr        = 1'b0;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (head_valid)
        begin
            case (head.kind)
                CMD_HOLD:
                begin
                    pop      = 1'b1;
                    hold_wr  = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                CMD_DISCARD:
                begin
                    pop      = 1'b1;
                    cnt_next = '0;
                end
                CMD_EMIT:
                begin
                    if (load_ok)
                    begin
                        out_valid_next = 1'b1;
                        if (idx_reg < cnt_reg)
                        begin
                            // Release held words in order
                            out_byte_next = held_reg[idx_reg[HOLD_IDX_W-1:0]];
                            out_last_next = 1'b0;
                            idx_next      = idx_reg + CNT_W'(1);
                        end
                        else
                        begin
                            out_byte_next = head.data;
                            out_last_next = 1'b1;
                            idx_next      = '0;
                            cnt_next      = '0;
                            pop           = 1'b1;
                        end
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    // Hold buffer
    always_ff @(posedge clk)
    begin
        if (hold_wr)
        begin
            held_reg[cnt_reg[HOLD_IDX_W-1:0]] <= head.data;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    hold_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(HOLD_DEPTH))
        else $error("hold count beyond buffer depth");

    release_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= cnt_reg)
        else $error("release index passed hold count");

    hold_into_full: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head.kind == CMD_HOLD) |-> (cnt_reg < CNT_W'(HOLD_DEPTH)))
        else $error("hold command with full buffer");

endmodule

// File: hw/rtl/dsc_comment_line_filter.sv
`timescale 1ns / 1ps
// Path: an emitted word passes through the command queue and then the output register, unless
// queued behind others; held prefix words wait in the hold buffer for release.
// Throughput: one input word per cycle while the command queue is not full; the output stage,
// a single output register, moves one word per cycle while the sink is ready, held words first.
// The four-entry command queue takes up to three more input words while a released prefix drains.
// Reset (rst_n low, asynchronous) returns to line start, empties queue and hold, drops output valid.
module dsc_comment_line_filter
    import dclf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    dclf_in_if.sink      in_ch,
    dclf_out_if.source   out_ch
);

    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_full;
    logic q_empty;
    cmd_t q_head;

    dclf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    dclf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    dclf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_empty),
        .head       (q_head),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule
